// ===== design/deq_pkg.sv =====
// Shared widths and operation/status codes for the double-ended queue.
package deq_pkg;

  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 4;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PEEK       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

// ===== design/double_ended_queue_top.sv =====
// Bounded double-ended queue held in a circular buffer memory.
//
// Words live in a DEPTH-entry synchronous memory indexed by a head pointer and a fill
// count; the current front and back words are also kept in registers. Pushes, peeks and
// refused operations register their result on the input transfer. A successful pop that
// leaves the queue non-empty holds its result back while the new front or back word is
// read through the memory's single registered read port. One item is in work at a time;
// a new item is taken in the same cycle that the previous result is transferred.
// Codes 5 to 7 on func_i act as peek.
module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic        [deq_pkg::FUNC_W-1:0]     func_i,
  input  logic signed [deq_pkg::DATA_W-1:0]     push_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [deq_pkg::STATUS_W-1:0]   status_o,
  output logic signed [deq_pkg::DATA_W-1:0]     popped_value_o,
  output logic signed [deq_pkg::DATA_W-1:0]     front_value_o,
  output logic signed [deq_pkg::DATA_W-1:0]     back_value_o,
  output logic        [CW-1:0]                  fill_count_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = AW + 1;
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);
  localparam logic [SW-1:0] DepthSum = SW'(DEPTH);
  localparam logic [AW-1:0] LastPos  = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] wrap_pos(input logic [SW-1:0] x);
    logic [SW-1:0] r;
    r = (x >= DepthSum) ? x - DepthSum : x;
    return r[AW-1:0];
  endfunction

  // State
  logic [AW-1:0]              head_q, head_d;
  logic [CW-1:0]              occ_q, occ_d;
  logic signed [DATA_W-1:0]   front_q, front_d;
  logic signed [DATA_W-1:0]   back_q, back_d;
  logic                       busy_q;
  logic                       fill_front_q, fill_front_d;

  // Memory
  logic signed [DATA_W-1:0]   mem_q [DEPTH];
  logic signed [DATA_W-1:0]   rd_data_q;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;

  // Result register
  logic                       out_valid_q;
  logic [STATUS_W-1:0]        out_status_q;
  logic signed [DATA_W-1:0]   out_popped_q, out_front_q, out_back_q;
  logic [CW-1:0]              out_fill_q;
  logic                       out_empty_q, out_full_q;

  logic                       fire, full, empty;
  logic [STATUS_W-1:0]        status;
  logic signed [DATA_W-1:0]   popped;
  logic [AW-1:0]              head_dec, head_inc, tail_pos, back_prev;
  logic [SW-1:0]              tail_ext;

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign fire       = in_valid_i && in_ready_o;
  assign full       = (occ_q == DepthCnt);
  assign empty      = (occ_q == '0);

  always_comb begin
    head_dec  = (head_q == '0) ? LastPos : head_q - 1'b1;
    head_inc  = wrap_pos(SW'(head_q) + SW'(1));
    tail_pos  = wrap_pos(SW'(head_q) + SW'(occ_q));
    tail_ext  = SW'(tail_pos);
    // step back two slots from the free slot past the back
    back_prev = (tail_ext >= SW'(2)) ? AW'(tail_ext - SW'(2))
                                     : AW'(tail_ext + DepthSum - SW'(2));
  end

  always_comb begin
    head_d       = head_q;
    occ_d        = occ_q;
    front_d      = front_q;
    back_d       = back_q;
    fill_front_d = fill_front_q;
    mem_we       = 1'b0;
    mem_waddr    = tail_pos;
    mem_re       = 1'b0;
    mem_raddr    = head_inc;
    status       = STATUS_DONE;
    popped       = '0;
    case (func_i)
      FUNC_PUSH_FRONT: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          mem_we    = fire;
          mem_waddr = head_dec;
          head_d    = head_dec;
          occ_d     = occ_q + 1'b1;
          front_d   = push_value_i;
          if (empty) back_d = push_value_i;
        end
      end
      FUNC_PUSH_BACK: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          mem_we    = fire;
          mem_waddr = tail_pos;
          occ_d     = occ_q + 1'b1;
          back_d    = push_value_i;
          if (empty) front_d = push_value_i;
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          popped       = front_q;
          head_d       = head_inc;
          occ_d        = occ_q - 1'b1;
          mem_re       = fire && (occ_q != CW'(1));
          mem_raddr    = head_inc;
          fill_front_d = 1'b1;
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          popped       = back_q;
          occ_d        = occ_q - 1'b1;
          mem_re       = fire && (occ_q != CW'(1));
          mem_raddr    = back_prev;
          fill_front_d = 1'b0;
        end
      end
      default: begin
        status = STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= push_value_i;
    if (mem_re) rd_data_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      occ_q        <= '0;
      busy_q       <= 1'b0;
      fill_front_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        head_q       <= head_d;
        occ_q        <= occ_d;
        fill_front_q <= fill_front_d;
        // hold the result back while the memory read is in flight
        busy_q       <= mem_re;
        out_valid_q  <= !mem_re;
      end else if (busy_q) begin
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      front_q      <= front_d;
      back_q       <= back_d;
      out_status_q <= status;
      out_popped_q <= popped;
      out_front_q  <= (occ_d == '0) ? '0 : front_d;
      out_back_q   <= (occ_d == '0) ? '0 : back_d;
      out_fill_q   <= occ_d;
      out_empty_q  <= (occ_d == '0);
      out_full_q   <= (occ_d == DepthCnt);
    end else if (busy_q) begin
      if (fill_front_q) begin
        front_q     <= rd_data_q;
        out_front_q <= rd_data_q;
      end else begin
        back_q     <= rd_data_q;
        out_back_q <= rd_data_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign popped_value_o = out_popped_q;
  assign front_value_o  = out_front_q;
  assign back_value_o   = out_back_q;
  assign fill_count_o   = out_fill_q;
  assign is_empty_o     = out_empty_q;
  assign is_full_o      = out_full_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= DepthCnt)
    else $error("fill count above depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastPos)
    else $error("head pointer out of range");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q && out_valid_q)
    else $error("pending read did not complete in one cycle");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && mem_re |=> !fire && !out_valid_q)
    else $error("transfer taken while pop read pending");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_empty_q == (out_fill_q == '0)) &&
                    (out_full_q == (out_fill_q == DepthCnt)))
    else $error("result flags disagree with fill count");

endmodule

// ===== tb/tb_double_ended_queue_top.sv =====
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 100ps

module tb_double_ended_queue_top;
  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic [CNT_W-1:0]         fill;
    logic                     empty;
    logic                     full;
  } deq_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [FUNC_W-1:0]        func_i = FUNC_PEEK;
  logic signed [DATA_W-1:0] push_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic signed [DATA_W-1:0] popped_value_o;
  logic signed [DATA_W-1:0] front_value_o;
  logic signed [DATA_W-1:0] back_value_o;
  logic [CNT_W-1:0]         fill_count_o;
  logic                     is_empty_o;
  logic                     is_full_o;

  // Mirror of the queue contents
  logic signed [DATA_W-1:0] dq_slot [DEPTH];
  int                       dq_head = 0;
  int                       dq_count = 0;

  deq_result_t expected_results [$];
  int          err_count = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold_cycles = 0;

  double_ended_queue_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .fill_count_o  (fill_count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Apply one operation to the mirror and return the result it should produce.
  function automatic deq_result_t apply_deque_op(input logic [FUNC_W-1:0] op,
                                                 input logic signed [DATA_W-1:0] word);
    deq_result_t r;
    r = '{status: STATUS_DONE, popped: '0, front: '0, back: '0,
          fill: '0, empty: 1'b0, full: 1'b0};
    case (op)
      FUNC_PUSH_FRONT: begin
        if (dq_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          dq_head = (dq_head + DEPTH - 1) % DEPTH;
          dq_slot[dq_head] = word;
          dq_count++;
        end
      end
      FUNC_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          dq_slot[(dq_head + dq_count) % DEPTH] = word;
          dq_count++;
        end
      end
      FUNC_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.popped = dq_slot[dq_head];
          dq_head = (dq_head + 1) % DEPTH;
          dq_count--;
        end
      end
      FUNC_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.popped = dq_slot[(dq_head + dq_count - 1) % DEPTH];
          dq_count--;
        end
      end
      default: ; // peek and unused codes leave the queue alone
    endcase
    if (dq_count != 0) begin
      r.front = dq_slot[dq_head];
      r.back  = dq_slot[(dq_head + dq_count - 1) % DEPTH];
    end
    r.fill  = CNT_W'(dq_count);
    r.empty = (dq_count == 0);
    r.full  = (dq_count >= DEPTH);
    return r;
  endfunction

  // Predict on each input transfer, then check each output transfer.
  always @(posedge clk_i) begin : scoreboard
    deq_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(apply_deque_op(func_i, push_value_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("[%0t] result with nothing pending: st=%0d pop=%0d", $realtime,
                     status_o, popped_value_o);
          end
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status || popped_value_o !== want.popped ||
              front_value_o !== want.front || back_value_o !== want.back ||
              fill_count_o !== want.fill || is_empty_o !== want.empty ||
              is_full_o !== want.full) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("[%0t] mismatch exp st=%0d pop=%0d fr=%0d bk=%0d n=%0d e=%0b f=%0b",
                       $realtime, want.status, want.popped, want.front, want.back,
                       want.fill, want.empty, want.full);
              $display("             got st=%0d pop=%0d fr=%0d bk=%0d n=%0d e=%0b f=%0b",
                       status_o, popped_value_o, front_value_o, back_value_o,
                       fill_count_o, is_empty_o, is_full_o);
            end
          end
        end
      end
    end
  end

  // Result side: random stall per transfer, plus an optional long hold-off.
  initial begin : result_sink
    int gap;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = rx_idle_en ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Offer one operation; called and returns at a falling edge.
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic signed [DATA_W-1:0] word);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= op;
    push_value_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Random traffic that swings between filling and draining phases.
  task automatic run_random(input int n_items);
    logic [FUNC_W-1:0]        op;
    logic signed [DATA_W-1:0] word;
    int                       push_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 24 == 0) push_pct = $urandom_range(0, 1) ? 75 : 25;
      if ($urandom_range(0, 99) < 6) begin
        op = FUNC_W'($urandom_range(FUNC_PEEK, 2**FUNC_W - 1));
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      end else begin
        op = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
      end
      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = '1;
        2:       word = {1'b1, {(DATA_W-1){1'b0}}};
        3:       word = {1'b0, {(DATA_W-1){1'b1}}};
        default: word = $urandom;
      endcase
      send_op(op, word);
    end
  endtask

  task automatic test_empty_queue();
    send_op(FUNC_PEEK, 32'h1234_5678);
    send_op(FUNC_POP_FRONT, '0);
    send_op(FUNC_POP_BACK, '0);
    for (int op = FUNC_PEEK + 1; op < 2**FUNC_W; op++) begin
      send_op(FUNC_W'(op), '1);
    end
  endtask

  task automatic test_fill_and_drain();
    send_op(FUNC_PUSH_BACK, 32'sh7FFF_FFFF);
    send_op(FUNC_PUSH_FRONT, 32'sh8000_0000);
    send_op(FUNC_PUSH_BACK, 32'sh5555_5555);
    send_op(FUNC_PUSH_FRONT, 32'shAAAA_AAAA);
    // Queue is full: both pushes must be refused
    send_op(FUNC_PUSH_BACK, '1);
    send_op(FUNC_PUSH_FRONT, '0);
    send_op(FUNC_PEEK, '0);
    send_op(FUNC_POP_FRONT, '0);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_POP_FRONT, '0);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_POP_FRONT, '0);
  endtask

  task automatic test_random_with_gaps();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    run_random(350);
  endtask

  task automatic test_random_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(250);
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_cycles = 120;
    run_random(40);
  endtask

  task automatic test_random_one_sided();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    run_random(125);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    run_random(125);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_queue();
    test_fill_and_drain();
    test_random_with_gaps();
    test_random_streaming();
    test_output_backpressure();
    test_random_one_sided();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
